// ===== rtl/mtrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mtrs_pkg
// Shared types, constants and the tempering function of the MT19937 source.
// ----------------------------------------------------------------------------
package mtrs_pkg;

  localparam int unsigned MT_N     = 624;
  localparam int unsigned MT_M     = 397;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ADDR_W   = $clog2(MT_N);

  localparam logic [31:0] INIT_MULT   = 32'd1812433253;
  localparam logic [31:0] INIT_SEED   = 32'd19650218;
  localparam logic [31:0] PASS1_MULT  = 32'd1664525;
  localparam logic [31:0] PASS2_MULT  = 32'd1566083941;
  localparam logic [31:0] MATRIX_A    = 32'h9908b0df;
  localparam logic [31:0] TEMPER_B    = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C    = 32'hefc60000;
  localparam logic [31:0] UPPER_MASK  = 32'h80000000;
  localparam logic [31:0] LOWER_MASK  = 32'h7fffffff;

  // operation codes
  localparam logic [2:0] OP_RAW    = 3'd0;
  localparam logic [2:0] OP_BITS   = 3'd1;
  localparam logic [2:0] OP_BELOW  = 3'd2;
  localparam logic [2:0] OP_RAND53 = 3'd3;
  localparam logic [2:0] OP_RESEED = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SEED,
    ST_PI_MUL,
    ST_PI_ADD,
    ST_AR_RD,
    ST_AR_WR,
    ST_AR_WRAP,
    ST_PASS_END,
    ST_SEED_END,
    ST_BITLEN,
    ST_DRAW,
    ST_DRAW_CAP,
    ST_TW_INIT,
    ST_TW_C0,
    ST_TW_R1,
    ST_TW_R2,
    ST_TW_WR,
    ST_FINISH
  } mtrs_state_t;

  // output tempering of one state word
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== rtl/mtrs_ram.sv =====
// ----------------------------------------------------------------------------
// mtrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtrs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mt19937_random_source.sv =====
// ----------------------------------------------------------------------------
// mt19937_random_source
// MT19937 generator with key-array seeding and getrandbits/randbelow.
// ----------------------------------------------------------------------------
// One request at a time; in_tready is low while a request is worked on. The
// 624-word state sits in a single-port-read RAM, so every word costs a read
// and a capture. Every 624 words the state is refilled by a twist, word by
// word. Below-bound first scans the bound's bit length, one bit per cycle,
// then draws until the value falls below the bound. Reseed, and the seeding
// that runs right after reset before in_tready rises, are paced by the single
// shared 32x32 multiplier and the RAM port. Writing the seed does not reseed
// by itself.
// ----------------------------------------------------------------------------
module mt19937_random_source
  import mtrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[2:0], bit_count[9:3], bound[73:10], zero fill
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // value[63:0]
  output logic [63:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data
);

  mtrs_state_t state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W:0]   cnt_r, cnt_nxt;
  logic [ADDR_W:0]   pos_r, pos_nxt;
  logic        j_r, j_nxt;
  logic        pass_r, pass_nxt;
  logic        last_r, last_nxt;
  logic        klen2_r, klen2_nxt;
  logic        second_r, second_nxt;
  logic        reseed_r, reseed_nxt;
  logic [31:0] p_r, p_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [31:0] key0_r, key0_nxt;
  logic [31:0] key1_r, key1_nxt;
  logic [31:0] w_cur_r, w_cur_nxt;
  logic [31:0] w_succ_r, w_succ_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [6:0]  kk_r, kk_nxt;
  logic [63:0] bound_r, bound_nxt;
  logic [63:0] t_r, t_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] seed_r;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_rdata;

  // shared multiplier
  logic [31:0] mul_in, mul_k, mul_lo;
  assign mul_in = p_r ^ (p_r >> 30);
  always_comb begin
    case (state_r)
      ST_PI_MUL: mul_k = INIT_MULT;
      default:   mul_k = pass_r ? PASS2_MULT : PASS1_MULT;
    endcase
  end
  assign mul_lo = mul_in * mul_k;

  // draw datapath
  logic [31:0] tw;
  logic [6:0]  sh_full;
  logic [31:0] shifted;
  logic        kk_le32;
  logic [63:0] mag;
  logic [31:0] tw_y, tw_v;
  logic [31:0] ar_v;

  assign tw      = temper(ram_rdata);
  assign kk_le32 = (kk_r <= 7'd32);
  assign sh_full = kk_le32 ? (7'd32 - kk_r) : (7'd64 - kk_r);
  assign shifted = tw >> sh_full[4:0];
  assign mag     = seed_r[63] ? (~seed_r + 64'd1) : seed_r;
  assign tw_y    = (w_cur_r & UPPER_MASK) | (w_succ_r & LOWER_MASK);
  assign tw_v    = ram_rdata ^ (tw_y >> 1) ^ (tw_y[0] ? MATRIX_A : 32'd0);
  assign ar_v    = pass_r ? ((ram_rdata ^ prod_r) - 32'(idx_r))
                          : ((ram_rdata ^ prod_r) + (j_r ? key1_r : key0_r) + 32'(j_r));

  mtrs_ram #(.WIDTH(WORD_W), .DEPTH(MT_N)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // sequencer
  always_comb begin
    logic [63:0] r;
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    j_nxt      = j_r;
    pass_nxt   = pass_r;
    last_nxt   = last_r;
    klen2_nxt  = klen2_r;
    second_nxt = second_r;
    reseed_nxt = reseed_r;
    p_nxt      = p_r;
    prod_nxt   = prod_r;
    key0_nxt   = key0_r;
    key1_nxt   = key1_r;
    w_cur_nxt  = w_cur_r;
    w_succ_nxt = w_succ_r;
    lo_nxt     = lo_r;
    op_nxt     = op_r;
    kk_nxt     = kk_r;
    bound_nxt  = bound_r;
    t_nxt      = t_r;
    res_nxt    = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_wdata  = p_r;
    ram_raddr  = idx_r;
    r          = 64'd0;

    // result taken downstream
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tdata[2:0];
          bound_nxt  = in_tdata[73:10];
          t_nxt      = in_tdata[73:10];
          second_nxt = 1'b0;
          res_nxt    = 64'd0;
          kk_nxt     = 7'd32;
          case (in_tdata[2:0])
            OP_RAW:    state_nxt = ST_DRAW;
            OP_RAND53: state_nxt = ST_DRAW;
            OP_BITS: begin
              kk_nxt    = (in_tdata[9:3] > 7'd64) ? 7'd64 : in_tdata[9:3];
              state_nxt = (in_tdata[9:3] == 7'd0) ? ST_FINISH : ST_DRAW;
            end
            OP_BELOW: begin
              kk_nxt    = 7'd0;
              state_nxt = (in_tdata[73:10] <= 64'd1) ? ST_FINISH : ST_BITLEN;
            end
            OP_RESEED: begin
              reseed_nxt = 1'b1;
              state_nxt  = ST_SEED;
            end
            default:   state_nxt = ST_FINISH;
          endcase
        end
      end

      // seeding: key split and plain init
      ST_SEED: begin
        key0_nxt  = mag[31:0];
        key1_nxt  = mag[63:32];
        klen2_nxt = (mag[63:32] != 32'd0);
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = INIT_SEED;
        p_nxt     = INIT_SEED;
        idx_nxt   = ADDR_W'(1);
        state_nxt = ST_PI_MUL;
      end
      ST_PI_MUL: begin
        prod_nxt  = mul_lo;
        state_nxt = ST_PI_ADD;
      end
      ST_PI_ADD: begin
        ram_we    = 1'b1;
        ram_wdata = prod_r + 32'(idx_r);
        p_nxt     = prod_r + 32'(idx_r);
        if (idx_r == ADDR_W'(MT_N - 1)) begin
          idx_nxt   = ADDR_W'(1);
          j_nxt     = 1'b0;
          cnt_nxt   = (ADDR_W+1)'(MT_N);
          pass_nxt  = 1'b0;
          p_nxt     = INIT_SEED;
          state_nxt = ST_AR_RD;
        end else begin
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = ST_PI_MUL;
        end
      end

      // key mixing passes
      ST_AR_RD: begin
        prod_nxt  = mul_lo;
        state_nxt = ST_AR_WR;
      end
      ST_AR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ar_v;
        p_nxt     = ar_v;
        j_nxt     = klen2_r ? ~j_r : 1'b0;
        cnt_nxt   = cnt_r - (ADDR_W+1)'(1);
        last_nxt  = (cnt_r == (ADDR_W+1)'(1));
        if (idx_r == ADDR_W'(MT_N - 1)) begin
          idx_nxt   = ADDR_W'(1);
          state_nxt = ST_AR_WRAP;
        end else begin
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = (cnt_r == (ADDR_W+1)'(1)) ? ST_PASS_END : ST_AR_RD;
        end
      end
      ST_AR_WRAP: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = p_r;
        state_nxt = last_r ? ST_PASS_END : ST_AR_RD;
      end
      ST_PASS_END: begin
        if (!pass_r) begin
          pass_nxt  = 1'b1;
          cnt_nxt   = (ADDR_W+1)'(MT_N - 1);
          state_nxt = ST_AR_RD;
        end else begin
          state_nxt = ST_SEED_END;
        end
      end
      ST_SEED_END: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = UPPER_MASK;
        pos_nxt   = (ADDR_W+1)'(MT_N);
        res_nxt   = 64'd0;
        if (reseed_r) begin
          reseed_nxt = 1'b0;
          state_nxt  = ST_FINISH;
        end else begin
          state_nxt  = ST_IDLE;
        end
      end

      // bit length of the bound
      ST_BITLEN: begin
        if (t_r != 64'd0) begin
          kk_nxt = kk_r + 7'd1;
          t_nxt  = t_r >> 1;
        end else begin
          state_nxt = ST_DRAW;
        end
      end

      // word draw
      ST_DRAW: begin
        ram_raddr = pos_r[ADDR_W-1:0];
        if (pos_r >= (ADDR_W+1)'(MT_N)) begin
          state_nxt = ST_TW_INIT;
        end else begin
          pos_nxt   = pos_r + (ADDR_W+1)'(1);
          state_nxt = ST_DRAW_CAP;
        end
      end
      ST_DRAW_CAP: begin
        if (op_r == OP_RAND53) begin
          if (!second_r) begin
            lo_nxt     = tw;
            second_nxt = 1'b1;
            state_nxt  = ST_DRAW;
          end else begin
            res_nxt   = {11'd0, lo_r[31:5], tw[31:6]};
            state_nxt = ST_FINISH;
          end
        end else if (!kk_le32 && !second_r) begin
          lo_nxt     = tw;
          second_nxt = 1'b1;
          state_nxt  = ST_DRAW;
        end else begin
          r = kk_le32 ? {32'd0, shifted} : {shifted, lo_r};
          second_nxt = 1'b0;
          if (op_r == OP_BELOW && r >= bound_r) begin
            state_nxt = ST_DRAW;
          end else begin
            res_nxt   = r;
            state_nxt = ST_FINISH;
          end
        end
      end

      // twist refill
      ST_TW_INIT: begin
        ram_raddr = '0;
        idx_nxt   = '0;
        state_nxt = ST_TW_C0;
      end
      ST_TW_C0: begin
        w_cur_nxt = ram_rdata;
        state_nxt = ST_TW_R1;
      end
      ST_TW_R1: begin
        ram_raddr = (idx_r == ADDR_W'(MT_N - 1)) ? '0 : idx_r + ADDR_W'(1);
        state_nxt = ST_TW_R2;
      end
      ST_TW_R2: begin
        w_succ_nxt = ram_rdata;
        ram_raddr  = (idx_r < ADDR_W'(MT_N - MT_M)) ? idx_r + ADDR_W'(MT_M)
                                                    : idx_r - ADDR_W'(MT_N - MT_M);
        state_nxt  = ST_TW_WR;
      end
      ST_TW_WR: begin
        ram_we    = 1'b1;
        ram_wdata = tw_v;
        w_cur_nxt = w_succ_r;
        if (idx_r == ADDR_W'(MT_N - 1)) begin
          pos_nxt   = '0;
          state_nxt = ST_DRAW;
        end else begin
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = ST_TW_R1;
        end
      end

      // hand over the result
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SEED;
      reseed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      seed_r      <= 64'd0;
      pos_r       <= (ADDR_W+1)'(MT_N);
      second_r    <= 1'b0;
      pass_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reseed_r    <= reseed_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      second_r    <= second_nxt;
      pass_r      <= pass_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    j_r        <= j_nxt;
    last_r     <= last_nxt;
    klen2_r    <= klen2_nxt;
    p_r        <= p_nxt;
    prod_r     <= prod_nxt;
    key0_r     <= key0_nxt;
    key1_r     <= key1_nxt;
    w_cur_r    <= w_cur_nxt;
    w_succ_r   <= w_succ_nxt;
    lo_r       <= lo_nxt;
    op_r       <= op_nxt;
    kk_r       <= kk_nxt;
    bound_r    <= bound_nxt;
    t_r        <= t_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/mtrs_checker.sv =====
// ----------------------------------------------------------------------------
// mtrs_checker
// Port-level assertions for mt19937_random_source, bound to the top level.
// ----------------------------------------------------------------------------
module mtrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // seeding runs after reset, so no transaction is taken right away
  a_seed_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready in the cycle after a transaction");

  // a new result appears only as the block goes back to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result shown while still busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind mt19937_random_source mtrs_checker u_mtrs_checker (.*);
